// ===== hw/rtl/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg
// shared types, widths and bit order helpers for the signal repack scaler
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int FRAME_BYTES_DEF     = 8;
    localparam int SCALE_FRAC_BITS_DEF = 16;

    localparam int WORD_W   = 64;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 7;
    localparam int SCALE_W  = 32;
    localparam int OFFSET_W = 48;
    localparam int FLEN_W   = 4;
    localparam int HALF_W   = WORD_W / 2;
    localparam int PROD_W   = WORD_W + SCALE_W;
    localparam int SUM_W    = PROD_W + 2;

    typedef struct packed {
        logic [WORD_W-1:0]          source_frame;
        logic [POS_W-1:0]           source_start;
        logic [LEN_W-1:0]           source_length;
        logic [POS_W-1:0]           dest_start;
        logic [LEN_W-1:0]           dest_length;
        logic                       msb_first_order;
        logic signed [SCALE_W-1:0]  scale_factor;
        logic signed [OFFSET_W-1:0] offset_value;
        logic [FLEN_W-1:0]          frame_length;
        logic                       last_signal;
    } srs_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] dest_frame;
        logic [FLEN_W-1:0] dest_frame_length;
    } srs_frame_t;

    typedef struct packed {
        logic [POS_W-1:0]  dest_start;
        logic [LEN_W-1:0]  dest_length;
        logic              msb_first;
        logic              last;
        logic [FLEN_W-1:0] frame_length;
    } srs_info_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(WORD_W)) ? LEN_W'(WORD_W) : len;
    endfunction

    // sequential position p <-> frame bit p xor 7
    function automatic logic [WORD_W-1:0] byte_bitrev(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int b = 0; b < WORD_W / 8; b++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                r[8*b+k] = w[8*b+7-k];
            end
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] bitrev(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            r[i] = w[WORD_W-1-i];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/srs_extract.sv =====
// ----------------------------------------------------------------------------
// srs_extract
// input register, field extraction in either bit order, scale magnitude
// ----------------------------------------------------------------------------
module srs_extract #(
    parameter int FRAME_BYTES = srs_pkg::FRAME_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 item_valid,
    input  srs_pkg::srs_item_t                   item,
    output logic                                 raw_valid,
    output logic [srs_pkg::WORD_W-1:0]           raw,
    output logic [srs_pkg::SCALE_W-1:0]          scale_mag,
    output logic                                 scale_neg,
    output logic signed [srs_pkg::OFFSET_W-1:0]  offset,
    output srs_pkg::srs_info_t                   info
);
    import srs_pkg::*;

    localparam logic [WORD_W-1:0] ONES       = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] FRAME_MASK = ONES >> (WORD_W - FRAME_BYTES * 8);

    srs_item_t                   item_reg;
    logic                        item_valid_reg;
    logic [WORD_W-1:0]           raw_reg;
    logic [WORD_W-1:0]           raw_next;
    logic [SCALE_W-1:0]          scale_mag_reg;
    logic [SCALE_W-1:0]          scale_mag_next;
    logic                        scale_neg_reg;
    logic signed [OFFSET_W-1:0]  offset_reg;
    srs_info_t                   info_reg;
    srs_info_t                   info_next;
    logic                        raw_valid_reg;

    logic [LEN_W-1:0]  src_len;
    logic [WORD_W-1:0] src_bits;
    logic [WORD_W-1:0] seq_bits;
    logic [WORD_W-1:0] len_mask;
    logic [WORD_W-1:0] window;

    always_comb
    begin
        src_len  = clamp_len(item_reg.source_length);
        src_bits = item_reg.source_frame & FRAME_MASK;
        seq_bits = item_reg.msb_first_order ? byte_bitrev(src_bits) : src_bits;
        len_mask = ONES >> (LEN_W'(WORD_W) - src_len);
        window   = (seq_bits >> item_reg.source_start) & len_mask;
        raw_next = item_reg.msb_first_order ?
                   (bitrev(window) >> (LEN_W'(WORD_W) - src_len)) : window;

        scale_mag_next = item_reg.scale_factor[SCALE_W-1] ?
                         (~item_reg.scale_factor + SCALE_W'(1)) : item_reg.scale_factor;

        info_next.dest_start   = item_reg.dest_start;
        info_next.dest_length  = clamp_len(item_reg.dest_length);
        info_next.msb_first    = item_reg.msb_first_order;
        info_next.last         = item_reg.last_signal;
        info_next.frame_length = (item_reg.frame_length > FLEN_W'(FRAME_BYTES)) ?
                                 FLEN_W'(FRAME_BYTES) : item_reg.frame_length;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            raw_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            item_valid_reg <= item_valid;
            raw_valid_reg  <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg      <= item;
            raw_reg       <= raw_next;
            scale_mag_reg <= scale_mag_next;
            scale_neg_reg <= item_reg.scale_factor[SCALE_W-1];
            offset_reg    <= item_reg.offset_value;
            info_reg      <= info_next;
        end
    end

    assign raw_valid = raw_valid_reg;
    assign raw       = raw_reg;
    assign scale_mag = scale_mag_reg;
    assign scale_neg = scale_neg_reg;
    assign offset    = offset_reg;
    assign info      = info_reg;

endmodule

// ===== hw/rtl/srs_scale.sv =====
// ----------------------------------------------------------------------------
// srs_scale
// raw times scale as two 32x32 partial products, product merge, signed offset
// ----------------------------------------------------------------------------
module srs_scale (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 raw_valid,
    input  logic [srs_pkg::WORD_W-1:0]           raw,
    input  logic [srs_pkg::SCALE_W-1:0]          scale_mag,
    input  logic                                 scale_neg,
    input  logic signed [srs_pkg::OFFSET_W-1:0]  offset,
    input  srs_pkg::srs_info_t                   info,
    output logic                                 sum_valid,
    output logic [srs_pkg::SUM_W-1:0]            sum,
    output srs_pkg::srs_info_t                   sum_info
);
    import srs_pkg::*;

    logic [WORD_W-1:0]           part_lo_reg;
    logic [WORD_W-1:0]           part_lo_next;
    logic [WORD_W-1:0]           part_hi_reg;
    logic [WORD_W-1:0]           part_hi_next;
    logic                        neg_a_reg;
    logic signed [OFFSET_W-1:0]  offset_a_reg;
    srs_info_t                   info_a_reg;
    logic                        valid_a_reg;

    logic [PROD_W-1:0]           prod_reg;
    logic [PROD_W-1:0]           prod_next;
    logic                        neg_b_reg;
    logic signed [OFFSET_W-1:0]  offset_b_reg;
    srs_info_t                   info_b_reg;
    logic                        valid_b_reg;

    logic [SUM_W-1:0]            sum_reg;
    logic [SUM_W-1:0]            sum_next;
    srs_info_t                   info_c_reg;
    logic                        valid_c_reg;

    logic [SUM_W-1:0]            prod_ext;
    logic [SUM_W-1:0]            offset_ext;

    always_comb
    begin
        part_lo_next = WORD_W'(raw[HALF_W-1:0]) * WORD_W'(scale_mag);
        part_hi_next = WORD_W'(raw[WORD_W-1:HALF_W]) * WORD_W'(scale_mag);
        prod_next    = {{(PROD_W-WORD_W){1'b0}}, part_lo_reg}
                     + {part_hi_reg, {(PROD_W-WORD_W){1'b0}}};
        prod_ext     = {{(SUM_W-PROD_W){1'b0}}, prod_reg};
        offset_ext   = {{(SUM_W-OFFSET_W){offset_b_reg[OFFSET_W-1]}}, offset_b_reg};
        // negate the product by invert plus carry in
        sum_next     = (neg_b_reg ? ~prod_ext : prod_ext) + offset_ext
                     + SUM_W'(neg_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_a_reg <= raw_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            part_lo_reg  <= part_lo_next;
            part_hi_reg  <= part_hi_next;
            neg_a_reg    <= scale_neg;
            offset_a_reg <= offset;
            info_a_reg   <= info;

            prod_reg     <= prod_next;
            neg_b_reg    <= neg_a_reg;
            offset_b_reg <= offset_a_reg;
            info_b_reg   <= info_a_reg;

            sum_reg      <= sum_next;
            info_c_reg   <= info_b_reg;
        end
    end

    assign sum_valid = valid_c_reg;
    assign sum       = sum_reg;
    assign sum_info  = info_c_reg;

endmodule

// ===== hw/rtl/srs_pack.sv =====
// ----------------------------------------------------------------------------
// srs_pack
// saturation, bit packing into the destination frame, frame output register
// ----------------------------------------------------------------------------
module srs_pack #(
    parameter int FRAME_BYTES     = srs_pkg::FRAME_BYTES_DEF,
    parameter int SCALE_FRAC_BITS = srs_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       sum_valid,
    input  logic [srs_pkg::SUM_W-1:0]  sum,
    input  srs_pkg::srs_info_t         sum_info,
    output logic                       frame_valid,
    output srs_pkg::srs_frame_t        frame
);
    import srs_pkg::*;

    localparam logic [WORD_W-1:0] ONES       = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] FRAME_MASK = ONES >> (WORD_W - FRAME_BYTES * 8);

    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    srs_frame_t        frame_reg;
    srs_frame_t        frame_next;
    logic              frame_valid_reg;
    logic              frame_valid_next;

    logic [SUM_W-1:0]  shifted;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] len_mask;
    logic [WORD_W-1:0] seq_data;
    logic [WORD_W-1:0] seq_mask;
    logic [WORD_W-1:0] phys_data;
    logic [WORD_W-1:0] phys_mask;
    logic [WORD_W-1:0] merged;
    logic              emit;

    always_comb
    begin
        shifted = sum >> SCALE_FRAC_BITS;
        if (sum[SUM_W-1])
        begin
            value = '0;
        end
        else if (|shifted[SUM_W-2:WORD_W])
        begin
            value = ONES;
        end
        else
        begin
            value = shifted[WORD_W-1:0];
        end

        len_mask = ONES >> (LEN_W'(WORD_W) - sum_info.dest_length);
        seq_mask = (len_mask << sum_info.dest_start) & FRAME_MASK;
        if (sum_info.msb_first)
        begin
            seq_data = (bitrev(value) >> (LEN_W'(WORD_W) - sum_info.dest_length))
                       << sum_info.dest_start;
        end
        else
        begin
            seq_data = (value & len_mask) << sum_info.dest_start;
        end
        seq_data  = seq_data & seq_mask;
        phys_mask = sum_info.msb_first ? byte_bitrev(seq_mask) : seq_mask;
        phys_data = sum_info.msb_first ? byte_bitrev(seq_data) : seq_data;
        merged    = (acc_reg & ~phys_mask) | phys_data;

        emit = sum_valid && sum_info.last;

        acc_next = acc_reg;
        if (sum_valid)
        begin
            acc_next = sum_info.last ? '0 : merged;
        end

        frame_next.dest_frame        = merged;
        frame_next.dest_frame_length = sum_info.frame_length;
        frame_valid_next             = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= '0;
            frame_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg         <= acc_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

// ===== hw/rtl/signal_repack_scaler.sv =====
// an accepted item beat passes the item, raw, partial product, product, sum and frame registers
// throughput: one item beat per cycle while the frame output is not stalled
// the pipeline depth is set by the 64x32 multiply, split into two 32x32
// partial products, the product merge and the signed offset add
// reset: all stage valids and the output valid clear, the destination frame accumulator clears
// ----------------------------------------------------------------------------
// signal_repack_scaler
// extracts one signal per beat, rescales it and packs it into a kept frame
// ----------------------------------------------------------------------------
module signal_repack_scaler #(
    parameter int FRAME_BYTES     = srs_pkg::FRAME_BYTES_DEF,
    parameter int SCALE_FRAC_BITS = srs_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  srs_pkg::srs_item_t   item,
    output logic                 frame_valid,
    input  logic                 frame_stall,
    output srs_pkg::srs_frame_t  frame
);
    import srs_pkg::*;

    logic                        advance;
    logic                        raw_valid;
    logic [WORD_W-1:0]           raw;
    logic [SCALE_W-1:0]          scale_mag;
    logic                        scale_neg;
    logic signed [OFFSET_W-1:0]  offset;
    srs_info_t                   info;
    logic                        sum_valid;
    logic [SUM_W-1:0]            sum;
    srs_info_t                   sum_info;

    assign advance    = !frame_valid || !frame_stall;
    assign item_stall = !advance;

    srs_extract #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_extract (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item),
        .raw_valid  (raw_valid),
        .raw        (raw),
        .scale_mag  (scale_mag),
        .scale_neg  (scale_neg),
        .offset     (offset),
        .info       (info)
    );

    srs_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .raw_valid (raw_valid),
        .raw       (raw),
        .scale_mag (scale_mag),
        .scale_neg (scale_neg),
        .offset    (offset),
        .info      (info),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_info  (sum_info)
    );

    srs_pack #(
        .FRAME_BYTES     (FRAME_BYTES),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .sum_valid   (sum_valid),
        .sum         (sum),
        .sum_info    (sum_info),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (frame_valid && frame_stall))
        else $error("item stall without a held frame beat");

    a_frame_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_valid) |-> $past(sum_valid && sum_info.last))
        else $error("frame beat without a last signal");

    a_frame_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> (frame.dest_frame_length <= FLEN_W'(FRAME_BYTES)))
        else $error("frame length above frame size");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// streams signal beats through signal_repack_scaler and checks every frame
// beat against a bit-exact model of extract, rescale, saturate and pack
// ----------------------------------------------------------------------------
module tb_top;

    import srs_pkg::*;

    localparam int FRAC      = SCALE_FRAC_BITS_DEF;
    localparam int FRAME_W   = FRAME_BYTES_DEF * 8;
    localparam int N_ITEMS   = 750;
    localparam int IDLE_PCT  = 28;
    localparam logic signed [SCALE_W-1:0] GAIN_ONE = 32'sh0001_0000;

    typedef struct {
        srs_item_t sig;
        bit        drain;
    } pend_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       item_valid  = 1'b0;
    logic       item_stall;
    srs_item_t  item        = '0;
    logic       frame_valid;
    logic       frame_stall = 1'b0;
    srs_frame_t frame;

    pend_t             item_q[$];
    srs_frame_t        frames_due[$];
    logic [WORD_W-1:0] frame_acc = '0;
    int                beats_in = 0;
    int                frames_checked = 0;
    int                errors = 0;
    logic              calm;

    assign calm = (beats_in >= 300) && (beats_in < 430);

    signal_repack_scaler uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

    always #4 clk = ~clk;

    function automatic int clip_len(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(WORD_W)) ? WORD_W : int'(len);
    endfunction

    function automatic logic [WORD_W-1:0] extract_field(input logic [WORD_W-1:0] src,
                                                       input logic [POS_W-1:0] start,
                                                       input logic [LEN_W-1:0] len_in,
                                                       input logic msb);
        logic [WORD_W-1:0] v;
        int len;
        int pos;
        int phys;
        v = '0;
        len = clip_len(len_in);
        for (int i = 0; i < len; i++)
        begin
            pos = int'(start) + i;
            if (pos < FRAME_W)
            begin
                phys = msb ? (pos ^ 7) : pos;
                if (src[phys])
                    v[msb ? (len - 1 - i) : i] = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] pack_field(input logic [WORD_W-1:0] dst,
                                                    input logic [WORD_W-1:0] v,
                                                    input logic [POS_W-1:0] start,
                                                    input logic [LEN_W-1:0] len_in,
                                                    input logic msb);
        int len;
        int pos;
        int phys;
        len = clip_len(len_in);
        for (int i = 0; i < len; i++)
        begin
            pos = int'(start) + i;
            if (pos < FRAME_W)
            begin
                phys = msb ? (pos ^ 7) : pos;
                dst[phys] = v[msb ? (len - 1 - i) : i];
            end
        end
        return dst;
    endfunction

    // exact raw*gain + offset, truncate toward zero, clamp to 0 .. 2^64-1
    function automatic logic [WORD_W-1:0] rescale_value(input logic [WORD_W-1:0] raw,
                                                       input logic signed [SCALE_W-1:0] gain,
                                                       input logic signed [OFFSET_W-1:0] ofs);
        logic signed [127:0] r;
        logic signed [127:0] g;
        logic signed [127:0] o;
        logic signed [127:0] acc;
        logic signed [127:0] whole;
        r = $signed({64'd0, raw});
        g = 128'(gain);
        o = 128'(ofs);
        acc = r * g + o;
        if (acc < 0)
            return '0;
        whole = acc >>> FRAC;
        if (whole[127:WORD_W] != '0)
            return '1;
        return whole[WORD_W-1:0];
    endfunction

    function automatic srs_item_t mk(input logic [WORD_W-1:0] src,
                                     input int ss, input int sl,
                                     input int ds, input int dl,
                                     input logic msb,
                                     input logic signed [SCALE_W-1:0] gain,
                                     input logic signed [OFFSET_W-1:0] ofs,
                                     input int flen, input logic last);
        srs_item_t s;
        s.source_frame    = src;
        s.source_start    = POS_W'(ss);
        s.source_length   = LEN_W'(sl);
        s.dest_start      = POS_W'(ds);
        s.dest_length     = LEN_W'(dl);
        s.msb_first_order = msb;
        s.scale_factor    = gain;
        s.offset_value    = ofs;
        s.frame_length    = FLEN_W'(flen);
        s.last_signal     = last;
        return s;
    endfunction

    function automatic int random_len();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 0;
        if (r < 90)
            return $urandom_range(1, 64);
        return $urandom_range(65, 127);
    endfunction

    function automatic srs_item_t random_signal(input logic last);
        logic signed [SCALE_W-1:0]  gain;
        logic signed [OFFSET_W-1:0] ofs;
        int flen;
        case ($urandom_range(9))
            0, 1, 2, 3: gain = GAIN_ONE;
            4, 5:
            begin
                gain = SCALE_W'($urandom_range(32'h0004_0000));
                if ($urandom_range(1))
                    gain = -gain;
            end
            6:
            begin
                case ($urandom_range(3))
                    0: gain = 32'sh7FFF_FFFF;
                    1: gain = 32'sh8000_0000;
                    2: gain = '0;
                    default: gain = -GAIN_ONE;
                endcase
            end
            default: gain = $urandom;
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: ofs = '0;
            4, 5, 6:
            begin
                ofs = OFFSET_W'($urandom_range(32'h00FF_FFFF));
                if ($urandom_range(1))
                    ofs = -ofs;
            end
            default: ofs = OFFSET_W'({$urandom, $urandom});
        endcase
        flen = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(9, 15);
        return mk({$urandom, $urandom}, $urandom_range(63), random_len(),
                  $urandom_range(63), random_len(), 1'($urandom_range(1)),
                  gain, ofs, flen, last);
    endfunction

    function automatic void queue_signal(input srs_item_t s, input bit drain);
        pend_t p;
        p.sig = s;
        p.drain = drain;
        item_q.push_back(p);
    endfunction

    // item driver and frame prediction
    always @(posedge clk)
    begin : drive
        logic [WORD_W-1:0] raw_val;
        logic [WORD_W-1:0] scaled;
        srs_frame_t        due;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                raw_val = extract_field(item.source_frame, item.source_start,
                                        item.source_length, item.msb_first_order);
                scaled = rescale_value(raw_val, item.scale_factor, item.offset_value);
                frame_acc = pack_field(frame_acc, scaled, item.dest_start,
                                       item.dest_length, item.msb_first_order);
                beats_in++;
                if (item.last_signal)
                begin
                    due.dest_frame = frame_acc;
                    due.dest_frame_length = (item.frame_length > FLEN_W'(FRAME_BYTES_DEF))
                                            ? FLEN_W'(FRAME_BYTES_DEF) : item.frame_length;
                    frames_due.push_back(due);
                    frame_acc = '0;
                end
            end
            if (!item_valid || !item_stall)
            begin
                if (item_q.size() == 0 || (item_q[0].drain && frames_due.size() != 0)
                    || (!calm && $urandom_range(99) < IDLE_PCT))
                begin
                    item_valid <= 1'b0;
                end
                else
                begin
                    item <= item_q[0].sig;
                    item_valid <= 1'b1;
                    item_q.pop_front();
                end
            end
        end
    end

    // frame monitor
    always @(posedge clk)
    begin : watch
        srs_frame_t want;
        if (!rst_n)
        begin
            frame_stall <= 1'b0;
        end
        else
        begin
            if (frame_valid && !frame_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected frame beat: expected none, actual %h len %0d",
                             $realtime, frame.dest_frame, frame.dest_frame_length);
                end
                else
                begin
                    want = frames_due.pop_front();
                    frames_checked++;
                    if (frame.dest_frame !== want.dest_frame)
                    begin
                        errors++;
                        $display("%0t dest_frame mismatch: expected %h, actual %h",
                                 $realtime, want.dest_frame, frame.dest_frame);
                    end
                    if (frame.dest_frame_length !== want.dest_frame_length)
                    begin
                        errors++;
                        $display("%0t dest_frame_length mismatch: expected %0d, actual %0d",
                                 $realtime, want.dest_frame_length, frame.dest_frame_length);
                    end
                end
            end
            frame_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        int n_queued;
        int n_sigs;
        int next_drain;
        bit drain;

        // bit order, zero length, full width, clipped lengths and positions
        queue_signal(mk(64'hA5, 0, 8, 0, 8, 1'b0, GAIN_ONE, '0, 8, 1'b0), 1'b0);
        queue_signal(mk(64'hA5, 0, 8, 8, 8, 1'b1, GAIN_ONE, '0, 8, 1'b1), 1'b0);
        queue_signal(mk('1, 0, 0, 16, 16, 1'b0, GAIN_ONE, 48'sh0012_3456_0000, 2, 1'b1), 1'b0);
        queue_signal(mk('1, 0, 64, 0, 64, 1'b0, GAIN_ONE, '0, 15, 1'b1), 1'b0);
        queue_signal(mk('1, 63, 127, 60, 100, 1'b1, GAIN_ONE, '0, 8, 1'b1), 1'b0);
        // negative result clears bits already written
        queue_signal(mk(64'hFF, 0, 8, 0, 16, 1'b0, GAIN_ONE, '0, 0, 1'b0), 1'b0);
        queue_signal(mk(64'hFF, 0, 8, 4, 8, 1'b0, -GAIN_ONE, '0, 1, 1'b1), 1'b0);
        // overflow and offset extremes
        queue_signal(mk('1, 0, 64, 0, 64, 1'b0, 32'sh7FFF_FFFF, '0, 8, 1'b1), 1'b0);
        queue_signal(mk('0, 0, 8, 0, 64, 1'b0, 32'sh8000_0000, 48'sh7FFF_FFFF_FFFF, 8, 1'b1),
                     1'b0);
        queue_signal(mk(64'h1, 0, 1, 0, 64, 1'b0, 32'sh8000_0000, 48'sh8000_0000_0000, 8, 1'b1),
                     1'b0);
        // fraction handling
        queue_signal(mk(64'h3, 0, 2, 0, 32, 1'b0, '0, -48'sd1, 8, 1'b1), 1'b0);
        queue_signal(mk(64'h3, 0, 2, 0, 32, 1'b0, 32'sh0000_8000, 48'sh0000_0000_FFFF, 8, 1'b1),
                     1'b0);
        queue_signal(mk('1, 0, 16, 8, 0, 1'b0, GAIN_ONE, '0, 8, 1'b1), 1'b0);
        // fields crossing byte borders and the frame end
        queue_signal(mk(64'h0123_4567_89AB_CDEF, 5, 12, 3, 12, 1'b1, GAIN_ONE, '0, 7, 1'b0),
                     1'b0);
        queue_signal(mk(64'hFEDC_BA98_7654_3210, 50, 20, 58, 12, 1'b1, GAIN_ONE,
                        48'sh0001_0000, 9, 1'b1), 1'b0);
        queue_signal(mk({$urandom, $urandom}, 10, 30, 20, 30, 1'b0, -32'sh0002_8000,
                        48'sh7FFF_0000_0000, 0, 1'b1), 1'b0);
        queue_signal(mk('0, 0, 64, 0, 64, 1'b1, GAIN_ONE, 48'sh7FFF_FFFF_FFFF, 8, 1'b1), 1'b0);

        n_queued = 0;
        next_drain = 0;
        while (n_queued < N_ITEMS)
        begin
            n_sigs = $urandom_range(1, 6);
            drain = (n_queued >= next_drain);
            if (drain)
                next_drain += 180;
            for (int k = 0; k < n_sigs; k++)
            begin
                queue_signal(random_signal(k == n_sigs - 1), drain && (k == 0));
                n_queued++;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (item_q.size() != 0 || item_valid || frames_due.size() != 0);
        repeat (16) @(posedge clk);

        $display("run covered %0d signal beats and %0d frame beats in both bit orders,",
                 beats_in, frames_checked);
        $display("with clipped lengths, out-of-frame positions and saturation; %0d mismatches",
                 errors);
        if (errors == 0)
            $display("** signal_repack_scaler: PASSED **");
        else
            $display("** signal_repack_scaler: FAILED **");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d frame beats outstanding", frames_due.size());
        $display("** signal_repack_scaler: FAILED **");
        $finish;
    end

endmodule

// ===== signal_repack_scaler.f =====
hw/rtl/srs_pkg.sv
hw/rtl/srs_extract.sv
hw/rtl/srs_scale.sv
hw/rtl/srs_pack.sv
hw/rtl/signal_repack_scaler.sv
bench/tb_top.sv
